// File: src/swsi_pkg.sv
// Shared types and constants for the bone-weight slot insert block.
package swsi_pkg;

   localparam int SLOTS = 4;
   localparam logic [15:0] WEIGHT_ONE = 16'd32768;

   localparam logic [1:0] OUTCOME_FREE     = 2'd0;
   localparam logic [1:0] OUTCOME_REPLACED = 2'd1;
   localparam logic [1:0] OUTCOME_DROPPED  = 2'd2;
   localparam logic [1:0] OUTCOME_ZERO_SUM = 2'd3;

   typedef struct packed {
      logic [SLOTS-1:0]       occ;
      logic [SLOTS-1:0][7:0]  bone;
      logic [SLOTS-1:0][15:0] wt;
   } rec_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_LOAD,
      ST_STEP,
      ST_DONE
   } state_type;

endpackage

// File: src/skin_weight_slot_insert.sv
// Top level: per-vertex four-slot bone-weight insertion with renormalization.
//
// Each transaction takes one vertex, bone and weight and returns one result with the
// vertex record as it stands afterwards. Records live in a single-port synchronous
// memory of VERTEX_COUNT words; after reset a clearing pass writes one word a cycle to
// every word, during which req_ready stays low. One transaction is processed at a
// time: a placement into a free slot, an out-of-range request or a full record whose
// weights sum to zero goes from ST_CALC straight to ST_DONE; any other full record,
// replaced or dropped, runs the shared restoring divider, two quotient bits a cycle, on
// each of the four weights in turn through ST_LOAD and ST_STEP. A new transaction is
// accepted while the previous result still waits in the output register.
module skin_weight_slot_insert #(
   parameter int VERTEX_COUNT = 4096,
   parameter int BONE_COUNT   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_vertex_id,
   input  logic [7:0]  req_bone_id,
   input  logic [15:0] req_bone_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_outcome,
   output logic [7:0]  rsp_bone_of_slot0,
   output logic [7:0]  rsp_bone_of_slot1,
   output logic [7:0]  rsp_bone_of_slot2,
   output logic [7:0]  rsp_bone_of_slot3,
   output logic [15:0] rsp_weight_of_slot0,
   output logic [15:0] rsp_weight_of_slot1,
   output logic [15:0] rsp_weight_of_slot2,
   output logic [15:0] rsp_weight_of_slot3,
   output logic [3:0]  rsp_slots_occupied
);

   localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

   swsi_pkg::rec_type   mem [VERTEX_COUNT];
   swsi_pkg::rec_type   rd_ff;
   swsi_pkg::rec_type   rec_ff, rec_in;
   swsi_pkg::rec_type   rsp_rec_ff;
   swsi_pkg::state_type state_ff, state_in;

   logic [AW-1:0]  clr_ff;
   logic [AW-1:0]  addr_ff;
   logic [7:0]     bone_ff;
   logic [15:0]    wgt_ff;
   logic           vok_ff, bok_ff, wr_ff;
   logic [1:0]     outcome_ff, outcome_in;
   logic [1:0]     rsp_outcome_ff;
   logic           rsp_valid_ff;
   logic [17:0]    sum_ff, sum_in;
   logic [17:0]    rem_ff;
   logic [15:0]    dvd_ff, quo_ff;
   logic [2:0]     step_ff;
   logic [1:0]     idx_ff;
   logic           accept, out_free, full_path;
   logic [15:0]    wsat;
   logic [31:0]    num;
   logic [18:0]    t1, t2;
   logic [17:0]    r1, r2;
   logic           b1, b2;
   logic [15:0]    qfin;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wsat     = (req_bone_weight > swsi_pkg::WEIGHT_ONE) ? swsi_pkg::WEIGHT_ONE
                                                               : req_bone_weight;

   // insertion decision on the record just read
   always_comb begin
      logic       found, freef;
      logic [1:0] li, fi;
      logic [15:0] lw;
      rec_in     = rd_ff;
      outcome_in = swsi_pkg::OUTCOME_DROPPED;
      found      = 1'b0;
      freef      = 1'b0;
      li         = 2'd0;
      fi         = 2'd0;
      lw         = wgt_ff;
      full_path  = 1'b0;
      for (int i = swsi_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!rd_ff.occ[i]) begin
            freef = 1'b1;
            fi    = 2'(i);
         end
      end
      for (int i = 0; i < swsi_pkg::SLOTS; i++) begin
         if (rd_ff.wt[i] < lw) begin
            found = 1'b1;
            li    = 2'(i);
            lw    = rd_ff.wt[i];
         end
      end
      if (!vok_ff) begin
         rec_in = '0;
      end else if (bok_ff) begin
         if (freef) begin
            rec_in.occ[fi]  = 1'b1;
            rec_in.bone[fi] = bone_ff;
            rec_in.wt[fi]   = wgt_ff;
            outcome_in      = swsi_pkg::OUTCOME_FREE;
         end else begin
            full_path = 1'b1;
            if (found) begin
               rec_in.bone[li] = bone_ff;
               rec_in.wt[li]   = wgt_ff;
               outcome_in      = swsi_pkg::OUTCOME_REPLACED;
            end
         end
      end
      sum_in = 18'(rec_in.wt[0]) + 18'(rec_in.wt[1]) + 18'(rec_in.wt[2]) + 18'(rec_in.wt[3]);
   end

   // two restoring division steps
   always_comb begin
      num  = {1'b0, rec_ff.wt[idx_ff], 15'd0} + {15'd0, sum_ff[17:1]};
      t1   = {rem_ff, dvd_ff[15]};
      b1   = (t1 >= {1'b0, sum_ff});
      r1   = b1 ? 18'(t1 - {1'b0, sum_ff}) : t1[17:0];
      t2   = {r1, dvd_ff[14]};
      b2   = (t2 >= {1'b0, sum_ff});
      r2   = b2 ? 18'(t2 - {1'b0, sum_ff}) : t2[17:0];
      qfin = {quo_ff[13:0], b1, b2};
      if (qfin > swsi_pkg::WEIGHT_ONE) qfin = swsi_pkg::WEIGHT_ONE;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swsi_pkg::ST_CLEAR: if (clr_ff == AW'(VERTEX_COUNT - 1)) state_in = swsi_pkg::ST_IDLE;
         swsi_pkg::ST_IDLE:  if (accept) state_in = swsi_pkg::ST_CALC;
         swsi_pkg::ST_CALC: begin
            if (full_path && sum_in != 18'd0) state_in = swsi_pkg::ST_LOAD;
            else state_in = swsi_pkg::ST_DONE;
         end
         swsi_pkg::ST_LOAD:  state_in = swsi_pkg::ST_STEP;
         swsi_pkg::ST_STEP: begin
            if (step_ff == 3'd7) begin
               state_in = (idx_ff == 2'd3) ? swsi_pkg::ST_DONE : swsi_pkg::ST_LOAD;
            end
         end
         swsi_pkg::ST_DONE:  if (out_free) state_in = swsi_pkg::ST_IDLE;
         default:            state_in = swsi_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == swsi_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swsi_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == swsi_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (state_ff == swsi_pkg::ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == swsi_pkg::ST_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (state_ff == swsi_pkg::ST_DONE && wr_ff) begin
         mem[addr_ff] <= rec_ff;
      end
      if (accept) rd_ff <= mem[AW'(req_vertex_id)];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         swsi_pkg::ST_IDLE: begin
            if (accept) begin
               addr_ff <= AW'(req_vertex_id);
               bone_ff <= req_bone_id;
               wgt_ff  <= wsat;
               vok_ff  <= 32'(req_vertex_id) < 32'(VERTEX_COUNT);
               bok_ff  <= 32'(req_bone_id) < 32'(BONE_COUNT);
            end
         end
         swsi_pkg::ST_CALC: begin
            rec_ff  <= rec_in;
            sum_ff  <= sum_in;
            wr_ff   <= vok_ff && bok_ff;
            idx_ff  <= 2'd0;
            outcome_ff <= (full_path && sum_in == 18'd0) ? swsi_pkg::OUTCOME_ZERO_SUM
                                                          : outcome_in;
         end
         swsi_pkg::ST_LOAD: begin
            rem_ff  <= {2'b00, num[31:16]};
            dvd_ff  <= num[15:0];
            quo_ff  <= '0;
            step_ff <= 3'd0;
         end
         swsi_pkg::ST_STEP: begin
            rem_ff  <= r2;
            dvd_ff  <= {dvd_ff[13:0], 2'b00};
            quo_ff  <= {quo_ff[13:0], b1, b2};
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               rec_ff.wt[idx_ff] <= qfin;
               idx_ff <= idx_ff + 2'd1;
            end
         end
         swsi_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_rec_ff     <= rec_ff;
               rsp_outcome_ff <= outcome_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_bone_of_slot0   = rsp_rec_ff.bone[0];
   assign rsp_bone_of_slot1   = rsp_rec_ff.bone[1];
   assign rsp_bone_of_slot2   = rsp_rec_ff.bone[2];
   assign rsp_bone_of_slot3   = rsp_rec_ff.bone[3];
   assign rsp_weight_of_slot0 = rsp_rec_ff.wt[0];
   assign rsp_weight_of_slot1 = rsp_rec_ff.wt[1];
   assign rsp_weight_of_slot2 = rsp_rec_ff.wt[2];
   assign rsp_weight_of_slot3 = rsp_rec_ff.wt[3];
   assign rsp_slots_occupied  = rsp_rec_ff.occ;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == swsi_pkg::ST_CLEAR |-> !req_ready)
      else $error("transaction accepted during clearing pass");

   a_rem_below_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == swsi_pkg::ST_STEP |-> rem_ff < sum_ff)
      else $error("divider remainder not below divisor");

   a_free_sets_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == swsi_pkg::OUTCOME_FREE |-> rsp_slots_occupied != 4'h0)
      else $error("free-slot outcome with no occupied slot");

   a_replace_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == swsi_pkg::OUTCOME_REPLACED |-> rsp_slots_occupied == 4'hF)
      else $error("replacement on a record that was not full");

endmodule
